### sv/kwcmd_pkg.sv
package kwcmd_pkg;

    localparam int MAX_FRAME_LEN_DEF = 32;
    localparam int KW_COUNT          = 10;
    localparam int KW_MAXLEN         = 7;

    // Result codes: keyword index, or unknown command
    typedef enum logic [3:0] {
        CODE_ON      = 4'd0,
        CODE_OFF     = 4'd1,
        CODE_UP      = 4'd2,
        CODE_DOWN    = 4'd3,
        CODE_TIME    = 4'd4,
        CODE_WEATHER = 4'd5,
        CODE_TEMP    = 4'd6,
        CODE_HUM     = 4'd7,
        CODE_LIGHT   = 4'd8,
        CODE_AIR     = 4'd9,
        CODE_UNKNOWN = 4'd10
    } code_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_START_BYTE = 1'b0,
        REG_END_BYTE   = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] START_BYTE_RST = 8'd2;
    localparam logic [7:0] END_BYTE_RST   = 8'd3;

    // Decode outcome for the word held in the input stage
    typedef struct packed {
        logic  emit;
        code_t code;
    } kwcmd_result_t;

    // Keyword text, first character in the lowest byte
    function automatic logic [8*KW_MAXLEN-1:0] kw_word(input code_t k);
        logic [8*KW_MAXLEN-1:0] w;
        case (k)
            CODE_ON:      w = {40'h0, "n", "o"};
            CODE_OFF:     w = {32'h0, "f", "f", "o"};
            CODE_UP:      w = {40'h0, "p", "u"};
            CODE_DOWN:    w = {24'h0, "n", "w", "o", "d"};
            CODE_TIME:    w = {24'h0, "e", "m", "i", "t"};
            CODE_WEATHER: w = {"r", "e", "h", "t", "a", "e", "w"};
            CODE_TEMP:    w = {24'h0, "p", "m", "e", "t"};
            CODE_HUM:     w = {32'h0, "m", "u", "h"};
            CODE_LIGHT:   w = {16'h0, "t", "h", "g", "i", "l"};
            CODE_AIR:     w = {32'h0, "r", "i", "a"};
            default:      w = '0;
        endcase
        return w;
    endfunction

    // Keyword length in characters
    function automatic logic [2:0] kw_len(input code_t k);
        logic [2:0] n;
        case (k)
            CODE_ON:      n = 3'd2;
            CODE_OFF:     n = 3'd3;
            CODE_UP:      n = 3'd2;
            CODE_DOWN:    n = 3'd4;
            CODE_TIME:    n = 3'd4;
            CODE_WEATHER: n = 3'd7;
            CODE_TEMP:    n = 3'd4;
            CODE_HUM:     n = 3'd3;
            CODE_LIGHT:   n = 3'd5;
            CODE_AIR:     n = 3'd3;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

### sv/framed_keyword_command_decoder_core.sv
// Framed keyword command decoder. Takes one received byte per word on the
// slave stream and returns at most one result word per closed frame: the
// keyword index 0..9 (on, off, up, down, time, weather, temp, hum, light,
// air) or 10 for an unknown command; a frame that only begins with a keyword
// gives no word. A word is accepted every cycle unless input stalls. A result
// word is offered once its end byte has passed the input register and the
// result register around the keyword match, which updates one match flag per
// keyword as each byte is stored. Input stalls only while a result waits in
// the output register and the held byte would give another result. The user
// writes start_byte (index 0), end_byte (index 1) only when idle; unenforced.
module framed_keyword_command_decoder_core #(
    parameter int MAX_FRAME_LEN = kwcmd_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [3:0] result_code, [7:4] zero
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import kwcmd_pkg::*;

    logic [7:0]    start_byte_reg;
    logic [7:0]    end_byte_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    code_t         out_code_reg;
    kwcmd_result_t res;
    logic          out_free;
    logic          s1_move;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg   <= END_BYTE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_START_BYTE: start_byte_reg <= cfg_data;
                REG_END_BYTE:   end_byte_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Handshake: the input stage moves on unless it has a result and no room
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = in_valid_reg && (!res.emit || out_free);
    assign s_tready = !in_valid_reg || s1_move;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    kwcmd_tracker #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_move),
        .rx_byte    (in_byte_reg),
        .start_byte (start_byte_reg),
        .end_byte   (end_byte_reg),
        .result     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move && res.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && res.emit)
            out_code_reg <= res.code;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_code_reg};

    // Checks
    a_emit_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && res.emit |-> in_byte_reg == end_byte_reg)
        else $error("result from a word that is not the end byte");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_code_reg <= CODE_UNKNOWN)
        else $error("result code out of range");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !s1_move |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input stage lost a stalled word");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted word not held in input stage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(s1_move && res.emit))
        else $error("waiting result overwritten");

endmodule

### sv/kwcmd_tracker.sv
module kwcmd_tracker #(
    parameter int MAX_FRAME_LEN = kwcmd_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            start_byte,
    input  logic [7:0]            end_byte,
    output kwcmd_pkg::kwcmd_result_t result
);
    import kwcmd_pkg::*;

    localparam int LW = $clog2(MAX_FRAME_LEN + 1);

    logic                open_reg, open_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [KW_COUNT-1:0] match_reg, match_next;

    logic                   is_start;
    logic                   is_end;
    logic                   dec_emit;
    code_t                  dec_code;
    logic [7:0]             kw_ch;
    logic [8*KW_MAXLEN-1:0] kw_w;

    assign is_start = (rx_byte == start_byte);
    assign is_end   = !is_start && (rx_byte == end_byte);

    // Priority decode over the match flags: lowest keyword that is a prefix wins
    always_comb
    begin
        dec_emit = 1'b1;
        dec_code = CODE_UNKNOWN;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (match_reg[k] && (len_reg >= LW'(kw_len(code_t'(k)))))
            begin
                dec_emit = (len_reg == LW'(kw_len(code_t'(k))));
                dec_code = code_t'(k);
            end
        end
    end

    assign result.emit = is_end && open_reg && (len_reg != '0) && dec_emit;
    assign result.code = dec_code;

    // Frame state and per-keyword match flags, one byte per step
    always_comb
    begin
        open_next  = open_reg;
        len_next   = len_reg;
        match_next = match_reg;
        kw_ch      = '0;
        kw_w       = '0;
        if (step)
        begin
            if (is_start)
            begin
                open_next  = 1'b1;
                len_next   = '0;
                match_next = '1;
            end
            else if (is_end)
            begin
                if (open_reg && (len_reg != '0))
                begin
                    open_next = 1'b0;
                    len_next  = '0;
                end
            end
            else if (open_reg && (len_reg < LW'(MAX_FRAME_LEN)))
            begin
                len_next = len_reg + LW'(1);
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (len_reg < LW'(kw_len(code_t'(k))))
                    begin
                        kw_w  = kw_word(code_t'(k));
                        kw_ch = kw_w[{len_reg[2:0], 3'b000} +: 8];
                        match_next[k] = match_reg[k] && (rx_byte == kw_ch);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            len_reg   <= '0;
            match_reg <= '0;
        end
        else
        begin
            open_reg  <= open_next;
            len_reg   <= len_next;
            match_reg <= match_next;
        end
    end

endmodule
